>>> rtl/core/rfch_pkg.sv
// ----------------------------------------------------------------------------
// rfch_pkg: shared types and constants for the ray/face closest hit block
// Fixed-point formats, register and side codes, state and control types.
// ----------------------------------------------------------------------------
package rfch_pkg;

  localparam int GRID_SIZE = 64;
  localparam int CELL_SIZE = 4096;
  localparam int TAG_W     = 16;
  localparam int CELL_W    = 6;
  localparam int SIDE_W    = 3;
  localparam int COORD_W   = 32;
  localparam int FRAC_W    = 12;
  localparam int NUM_W     = COORD_W + FRAC_W;
  localparam int CNT_W     = $clog2(NUM_W + 1);
  localparam int CORR_SH   = COORD_W - FRAC_W;
  localparam int CFG_IDX_W = 3;
  localparam int IN_DATA_W  = ((3 * CELL_W + TAG_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((TAG_W + COORD_W + 7) / 8) * 8;

  localparam logic signed [COORD_W-1:0] BEST_RESET = 32'sh0400_0000;
  localparam logic signed [COORD_W-1:0] NEG_EPS    = -32'sd1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Z    = 3'd5;

  // highest valid side code (-z); side[2:1] is the axis, side[0] the sign
  localparam logic [SIDE_W-1:0] SIDE_NEG_Z = 3'd5;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PREP, ST_LOAD, ST_DIVIDE, ST_NEGATE, ST_CORRECT, ST_CHECK, ST_RESULT
  } state_t;

  // correction of the hit-point product for the 32-bit wrap of k
  typedef enum logic [1:0] {
    CORR_NONE, CORR_ADD, CORR_SUB
  } corr_t;

  typedef struct packed {
    logic busy;
    logic step;
    logic q_bit;
    logic last;
  } div_out_t;

  typedef struct packed {
    logic  acc_clr;
    logic  fin_neg;
    logic  fin_corr;
    logic  k_neg;
    corr_t corr;
  } lane_ctrl_t;

  // face plane coordinate on one axis: block centre plus or minus half a cell
  function automatic logic signed [COORD_W-1:0] plane_coord(
    input logic [CELL_W-1:0] cell_idx,
    input logic              up
  );
    logic signed [COORD_W-1:0] base;
    base = $signed(COORD_W'(cell_idx)) - COORD_W'(GRID_SIZE / 2);
    base = COORD_W'(base * CELL_SIZE);
    if (up) begin
      return base + COORD_W'(CELL_SIZE / 2);
    end
    return base - COORD_W'(CELL_SIZE / 2);
  endfunction

endpackage

>>> rtl/core/rfch_div.sv
// ----------------------------------------------------------------------------
// rfch_div: bit-serial restoring divider
// Divides (num << FRAC_W) by den, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module rfch_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  logic [rfch_pkg::COORD_W-1:0]  num_mag,
  input  logic [rfch_pkg::COORD_W-1:0]  den_mag,
  output rfch_pkg::div_out_t            dq,
  output logic [rfch_pkg::COORD_W-1:0]  q_low
);

  logic                          busy_r, busy_nxt;
  logic [rfch_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [rfch_pkg::COORD_W-1:0]  rem_r, rem_nxt;
  logic [rfch_pkg::NUM_W-1:0]    num_r, num_nxt;
  logic [rfch_pkg::COORD_W-1:0]  den_r, den_nxt;
  logic [rfch_pkg::COORD_W-1:0]  q_r, q_nxt;
  logic [rfch_pkg::COORD_W:0]    trial;
  logic [rfch_pkg::COORD_W+1:0]  diff;
  logic                          ge;

  assign trial = {rem_r, num_r[rfch_pkg::NUM_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, den_r};
  assign ge    = !diff[rfch_pkg::COORD_W+1];

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    if (load) begin
      busy_nxt = 1'b1;
      cnt_nxt  = rfch_pkg::CNT_W'(rfch_pkg::NUM_W);
      rem_nxt  = '0;
      num_nxt  = {num_mag, rfch_pkg::FRAC_W'(0)};
      den_nxt  = den_mag;
    end else if (busy_r) begin
      cnt_nxt = cnt_r - rfch_pkg::CNT_W'(1);
      rem_nxt = ge ? diff[rfch_pkg::COORD_W-1:0] : trial[rfch_pkg::COORD_W-1:0];
      num_nxt = {num_r[rfch_pkg::NUM_W-2:0], 1'b0};
      q_nxt   = {q_r[rfch_pkg::COORD_W-2:0], ge};
      if (cnt_r == rfch_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  // only the low COORD_W quotient bits feed the hit-point lanes
  assign dq.busy  = busy_r;
  assign dq.step  = busy_r && (cnt_r <= rfch_pkg::CNT_W'(rfch_pkg::COORD_W));
  assign dq.q_bit = ge;
  assign dq.last  = busy_r && (cnt_r == rfch_pkg::CNT_W'(1));
  assign q_low    = q_r;

endmodule

>>> rtl/core/rfch_lane.sv
// ----------------------------------------------------------------------------
// rfch_lane: hit-point lane for one in-plane axis
// Accumulates dir * k as quotient bits arrive, then tests the quad bounds.
// ----------------------------------------------------------------------------
module rfch_lane (
  input  logic                                clk,
  input  rfch_pkg::lane_ctrl_t                ctrl,
  input  rfch_pkg::div_out_t                  dq,
  input  logic signed [rfch_pkg::COORD_W-1:0] dir,
  input  logic signed [rfch_pkg::COORD_W-1:0] org_off,
  output logic                                in_quad
);

  logic [rfch_pkg::NUM_W-1:0]          acc_r, acc_nxt;
  logic [rfch_pkg::NUM_W-1:0]          pn_r, pn_nxt;
  logic [rfch_pkg::COORD_W-1:0]        m_r, m_nxt;
  logic [rfch_pkg::NUM_W-1:0]          dir_ext;
  logic [rfch_pkg::COORD_W-1:0]        corr_term;
  logic [rfch_pkg::COORD_W-1:0]        shifted;
  logic signed [rfch_pkg::COORD_W-1:0] i_val;

  assign dir_ext = {{(rfch_pkg::NUM_W - rfch_pkg::COORD_W){dir[rfch_pkg::COORD_W-1]}}, dir};
  assign shifted = {dir[rfch_pkg::FRAC_W-1:0], rfch_pkg::CORR_SH'(0)};

  always_comb begin
    unique case (ctrl.corr)
      rfch_pkg::CORR_ADD: corr_term = shifted;
      rfch_pkg::CORR_SUB: corr_term = rfch_pkg::COORD_W'(0) - shifted;
      default:            corr_term = '0;
    endcase
  end

  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.acc_clr) begin
      acc_nxt = '0;
    end else if (dq.step) begin
      // Horner step: quotient bits arrive MSB first
      acc_nxt = {acc_r[rfch_pkg::NUM_W-2:0], 1'b0} + (dq.q_bit ? dir_ext : '0);
    end
    pn_nxt = pn_r;
    if (ctrl.fin_neg) begin
      pn_nxt = ctrl.k_neg ? rfch_pkg::NUM_W'(0) - acc_r : acc_r;
    end
    m_nxt = m_r;
    if (ctrl.fin_corr) begin
      m_nxt = pn_r[rfch_pkg::NUM_W-1:rfch_pkg::FRAC_W] + corr_term;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    pn_r  <= pn_nxt;
    m_r   <= m_nxt;
  end

  assign i_val   = m_r + org_off;
  assign in_quad = !i_val[rfch_pkg::COORD_W-1] &&
                   (i_val < rfch_pkg::COORD_W'(rfch_pkg::CELL_SIZE));

endmodule

>>> rtl/core/ray_face_closest_hit_top.sv
// ----------------------------------------------------------------------------
// ray_face_closest_hit_top: closest hit of a ray against a stream of faces
// Holds the ray in registers and keeps the nearest face hit so far.
// ----------------------------------------------------------------------------
// Usage:
//   Write the ray origin and direction (signed 20.12) on the cfg_ port while
//   the block is idle. Send faces on the in_ stream: tdata carries the cell
//   indexes and the tag, tuser the side code, tlast marks the last face.
//   The face marked last produces one item on the out_ stream: tuser is the
//   hit flag, tdata the tag and distance of the closest hit (zeros if none),
//   and the running best then returns to its reset values.
//   A face that the ray can hit passes the prepare, load, divide, negate,
//   correct, check and result states before the next face can be taken;
//   the divide is the bit-serial divide of the 20.12 quotient, which also
//   feeds the two hit-point lanes bit by bit. A face that the ray cannot
//   hit (back face, parallel or unused side code) goes from load to result.
//   Results sit in an output register; a stalled receiver only holds the
//   block when a further last face finishes before the earlier result left.
//   Reset (rst_n low at a clock edge) clears the ray, the best hit and the
//   output stream.
// ----------------------------------------------------------------------------
module ray_face_closest_hit_top (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_we,
  input  logic [rfch_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rfch_pkg::COORD_W-1:0]       cfg_data,
  // faces
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // cell_x, cell_y, cell_z, face_tag, zero fill
  input  logic [rfch_pkg::IN_DATA_W-1:0]     in_tdata,
  // face_side
  input  logic [rfch_pkg::SIDE_W-1:0]        in_tuser,
  input  logic                               in_tlast,
  // results
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // hit_tag, hit_distance
  output logic [rfch_pkg::OUT_DATA_W-1:0]    out_tdata,
  // hit_found
  output logic                               out_tuser
);

  localparam int CW = rfch_pkg::COORD_W;
  localparam int EW = rfch_pkg::CELL_W;

  rfch_pkg::state_t state_r, state_nxt;

  // ray registers
  logic signed [CW-1:0] ray_ox_r, ray_oy_r, ray_oz_r;
  logic signed [CW-1:0] ray_vx_r, ray_vy_r, ray_vz_r;
  logic signed [CW-1:0] ray_ox_nxt, ray_oy_nxt, ray_oz_nxt;
  logic signed [CW-1:0] ray_vx_nxt, ray_vy_nxt, ray_vz_nxt;

  // running best
  logic signed [CW-1:0]             best_dist_r, best_dist_nxt;
  logic [rfch_pkg::TAG_W-1:0]       best_tag_r, best_tag_nxt;
  logic                             any_hit_r, any_hit_nxt;

  // face item
  logic [EW-1:0]                    cell_x_r, cell_y_r, cell_z_r;
  logic [EW-1:0]                    cell_x_nxt, cell_y_nxt, cell_z_nxt;
  logic [rfch_pkg::SIDE_W-1:0]      side_r, side_nxt;
  logic [rfch_pkg::TAG_W-1:0]       tag_r, tag_nxt;
  logic                             last_r, last_nxt;

  // prepared operands
  logic signed [CW-1:0] p1_r, p1_nxt, p2_r, p2_nxt;
  logic signed [CW-1:0] va_r, va_nxt, vb_r, vb_nxt;
  logic signed [CW-1:0] da_r, da_nxt, db_r, db_nxt;
  logic                 side_ok_r, side_ok_nxt;
  logic                 k_neg_r, k_neg_nxt;
  logic signed [CW-1:0] k_r, k_nxt;
  rfch_pkg::corr_t      corr_r, corr_nxt;

  // output register
  logic                             out_valid_r, out_valid_nxt;
  logic                             out_found_r, out_found_nxt;
  logic [rfch_pkg::TAG_W-1:0]       out_tag_r, out_tag_nxt;
  logic [CW-1:0]                    out_dist_r, out_dist_nxt;

  // datapath wires
  logic [1:0]           axis;
  logic                 neg;
  logic signed [CW-1:0] px, py, pz;
  logic signed [CW-1:0] v_ax, o_ax, p_ax;
  logic signed [CW-1:0] va, oa, pa, vb, ob, pb;
  logic [CW-1:0]        num_mag, den_mag, q_low;
  logic                 test_ok, in_a, in_b, hit;
  logic                 in_acc, div_load, hit_upd, out_load, out_free;
  rfch_pkg::div_out_t   dq;
  rfch_pkg::lane_ctrl_t lctrl;

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  // ---------------- configuration ----------------
  always_comb begin
    ray_ox_nxt = ray_ox_r;
    ray_oy_nxt = ray_oy_r;
    ray_oz_nxt = ray_oz_r;
    ray_vx_nxt = ray_vx_r;
    ray_vy_nxt = ray_vy_r;
    ray_vz_nxt = ray_vz_r;
    if (cfg_we) begin
      unique case (cfg_index)
        rfch_pkg::REG_ORIGIN_X: ray_ox_nxt = cfg_data;
        rfch_pkg::REG_ORIGIN_Y: ray_oy_nxt = cfg_data;
        rfch_pkg::REG_ORIGIN_Z: ray_oz_nxt = cfg_data;
        rfch_pkg::REG_DIR_X:    ray_vx_nxt = cfg_data;
        rfch_pkg::REG_DIR_Y:    ray_vy_nxt = cfg_data;
        rfch_pkg::REG_DIR_Z:    ray_vz_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- operand preparation ----------------
  assign axis = side_r[rfch_pkg::SIDE_W-1:1];
  assign neg  = side_r[0];
  assign px   = rfch_pkg::plane_coord(cell_x_r, (axis == rfch_pkg::AXIS_X) && !neg);
  assign py   = rfch_pkg::plane_coord(cell_y_r, (axis == rfch_pkg::AXIS_Y) && !neg);
  assign pz   = rfch_pkg::plane_coord(cell_z_r, (axis == rfch_pkg::AXIS_Z) && !neg);

  always_comb begin
    unique case (axis)
      rfch_pkg::AXIS_X: begin
        v_ax = ray_vx_r; o_ax = ray_ox_r; p_ax = px;
        va = ray_vy_r; oa = ray_oy_r; pa = py;
        vb = ray_vz_r; ob = ray_oz_r; pb = pz;
      end
      rfch_pkg::AXIS_Y: begin
        v_ax = ray_vy_r; o_ax = ray_oy_r; p_ax = py;
        va = ray_vx_r; oa = ray_ox_r; pa = px;
        vb = ray_vz_r; ob = ray_oz_r; pb = pz;
      end
      rfch_pkg::AXIS_Z: begin
        v_ax = ray_vz_r; o_ax = ray_oz_r; p_ax = pz;
        va = ray_vx_r; oa = ray_ox_r; pa = px;
        vb = ray_vy_r; ob = ray_oy_r; pb = py;
      end
      default: begin
        v_ax = '0; o_ax = '0; p_ax = '0;
        va = '0; oa = '0; pa = '0;
        vb = '0; ob = '0; pb = '0;
      end
    endcase
  end

  assign test_ok = side_ok_r && (p1_r < rfch_pkg::NEG_EPS);
  assign den_mag = CW'(0) - p1_r;
  assign num_mag = p2_r[CW-1] ? CW'(0) - p2_r : p2_r;
  assign hit     = (k_r <= best_dist_r) && in_a && in_b;

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rfch_pkg::ST_IDLE:    if (in_tvalid) state_nxt = rfch_pkg::ST_PREP;
      rfch_pkg::ST_PREP:    state_nxt = rfch_pkg::ST_LOAD;
      rfch_pkg::ST_LOAD:    state_nxt = test_ok ? rfch_pkg::ST_DIVIDE : rfch_pkg::ST_RESULT;
      rfch_pkg::ST_DIVIDE:  if (dq.last) state_nxt = rfch_pkg::ST_NEGATE;
      rfch_pkg::ST_NEGATE:  state_nxt = rfch_pkg::ST_CORRECT;
      rfch_pkg::ST_CORRECT: state_nxt = rfch_pkg::ST_CHECK;
      rfch_pkg::ST_CHECK:   state_nxt = rfch_pkg::ST_RESULT;
      rfch_pkg::ST_RESULT:  if (!last_r || out_free) state_nxt = rfch_pkg::ST_IDLE;
      default:              state_nxt = rfch_pkg::ST_IDLE;
    endcase
  end

  // ---------------- state outputs ----------------
  always_comb begin
    in_tready      = 1'b0;
    div_load       = 1'b0;
    hit_upd        = 1'b0;
    out_load       = 1'b0;
    lctrl.acc_clr  = 1'b0;
    lctrl.fin_neg  = 1'b0;
    lctrl.fin_corr = 1'b0;
    lctrl.k_neg    = k_neg_r;
    lctrl.corr     = corr_r;
    unique case (state_r)
      rfch_pkg::ST_IDLE:    in_tready = 1'b1;
      rfch_pkg::ST_LOAD: begin
        div_load      = test_ok;
        lctrl.acc_clr = 1'b1;
      end
      rfch_pkg::ST_NEGATE:  lctrl.fin_neg = 1'b1;
      rfch_pkg::ST_CORRECT: lctrl.fin_corr = 1'b1;
      rfch_pkg::ST_CHECK:   hit_upd = hit;
      rfch_pkg::ST_RESULT:  out_load = last_r && out_free;
      default: ;
    endcase
  end

  // ---------------- datapath next values ----------------
  always_comb begin
    cell_x_nxt = cell_x_r;
    cell_y_nxt = cell_y_r;
    cell_z_nxt = cell_z_r;
    side_nxt   = side_r;
    tag_nxt    = tag_r;
    last_nxt   = last_r;
    if (in_acc) begin
      cell_x_nxt = in_tdata[EW-1:0];
      cell_y_nxt = in_tdata[2*EW-1:EW];
      cell_z_nxt = in_tdata[3*EW-1:2*EW];
      tag_nxt    = in_tdata[3*EW+rfch_pkg::TAG_W-1:3*EW];
      side_nxt   = in_tuser;
      last_nxt   = in_tlast;
    end

    p1_nxt      = p1_r;
    p2_nxt      = p2_r;
    va_nxt      = va_r;
    vb_nxt      = vb_r;
    da_nxt      = da_r;
    db_nxt      = db_r;
    side_ok_nxt = side_ok_r;
    if (state_r == rfch_pkg::ST_PREP) begin
      p1_nxt      = neg ? CW'(0) - v_ax : v_ax;
      p2_nxt      = neg ? o_ax - p_ax : p_ax - o_ax;
      va_nxt      = va;
      vb_nxt      = vb;
      da_nxt      = oa - pa;
      db_nxt      = ob - pb;
      side_ok_nxt = (side_r <= rfch_pkg::SIDE_NEG_Z);
    end

    k_neg_nxt = k_neg_r;
    if (state_r == rfch_pkg::ST_LOAD) begin
      // quotient sign: p1 is negative, so k is negative unless p2 is
      k_neg_nxt = !p2_r[CW-1];
    end

    k_nxt    = k_r;
    corr_nxt = corr_r;
    if (state_r == rfch_pkg::ST_NEGATE) begin
      k_nxt = k_neg_r ? CW'(0) - q_low : q_low;
      if (k_neg_r) begin
        corr_nxt = (q_low[CW-1] && (|q_low[CW-2:0])) ? rfch_pkg::CORR_ADD
                                                      : rfch_pkg::CORR_NONE;
      end else begin
        corr_nxt = q_low[CW-1] ? rfch_pkg::CORR_SUB : rfch_pkg::CORR_NONE;
      end
    end
  end

  // ---------------- best hit and result ----------------
  always_comb begin
    best_dist_nxt = best_dist_r;
    best_tag_nxt  = best_tag_r;
    any_hit_nxt   = any_hit_r;
    if (hit_upd) begin
      best_dist_nxt = k_r;
      best_tag_nxt  = tag_r;
      any_hit_nxt   = 1'b1;
    end else if (out_load) begin
      best_dist_nxt = rfch_pkg::BEST_RESET;
      best_tag_nxt  = '0;
      any_hit_nxt   = 1'b0;
    end

    out_found_nxt = out_found_r;
    out_tag_nxt   = out_tag_r;
    out_dist_nxt  = out_dist_r;
    if (out_load) begin
      out_found_nxt = any_hit_r;
      out_tag_nxt   = any_hit_r ? best_tag_r : '0;
      out_dist_nxt  = any_hit_r ? best_dist_r : '0;
    end
    out_valid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rfch_pkg::ST_IDLE;
      ray_ox_r    <= '0;
      ray_oy_r    <= '0;
      ray_oz_r    <= '0;
      ray_vx_r    <= '0;
      ray_vy_r    <= '0;
      ray_vz_r    <= '0;
      best_dist_r <= rfch_pkg::BEST_RESET;
      best_tag_r  <= '0;
      any_hit_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ray_ox_r    <= ray_ox_nxt;
      ray_oy_r    <= ray_oy_nxt;
      ray_oz_r    <= ray_oz_nxt;
      ray_vx_r    <= ray_vx_nxt;
      ray_vy_r    <= ray_vy_nxt;
      ray_vz_r    <= ray_vz_nxt;
      best_dist_r <= best_dist_nxt;
      best_tag_r  <= best_tag_nxt;
      any_hit_r   <= any_hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cell_x_r    <= cell_x_nxt;
    cell_y_r    <= cell_y_nxt;
    cell_z_r    <= cell_z_nxt;
    side_r      <= side_nxt;
    tag_r       <= tag_nxt;
    last_r      <= last_nxt;
    p1_r        <= p1_nxt;
    p2_r        <= p2_nxt;
    va_r        <= va_nxt;
    vb_r        <= vb_nxt;
    da_r        <= da_nxt;
    db_r        <= db_nxt;
    side_ok_r   <= side_ok_nxt;
    k_neg_r     <= k_neg_nxt;
    k_r         <= k_nxt;
    corr_r      <= corr_nxt;
    out_found_r <= out_found_nxt;
    out_tag_r   <= out_tag_nxt;
    out_dist_r  <= out_dist_nxt;
  end

  // ---------------- units ----------------
  rfch_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (div_load),
    .num_mag (num_mag),
    .den_mag (den_mag),
    .dq      (dq),
    .q_low   (q_low)
  );

  rfch_lane u_lane_a (
    .clk     (clk),
    .ctrl    (lctrl),
    .dq      (dq),
    .dir     (va_r),
    .org_off (da_r),
    .in_quad (in_a)
  );

  rfch_lane u_lane_b (
    .clk     (clk),
    .ctrl    (lctrl),
    .dq      (dq),
    .dir     (vb_r),
    .org_off (db_r),
    .in_quad (in_b)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = rfch_pkg::OUT_DATA_W'({out_dist_r, out_tag_r});
  assign out_tuser  = out_found_r;

  // ---------------- assertions ----------------
  a_accept_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !dq.busy)
    else $error("item accepted while the divider is busy");

  a_divide_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rfch_pkg::ST_DIVIDE) |-> dq.busy)
    else $error("divide state without an active divider");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("result without a hit carries non-zero data");

  a_best_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !any_hit_r |-> ((best_dist_r == rfch_pkg::BEST_RESET) && (best_tag_r == '0)))
    else $error("best hit not at its reset value while no hit is held");

endmodule
